// ===== design/cdconv_pkg.sv =====
// shared types, constants and calendar tables for the civil date converter
package cdconv_pkg;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam int SERIAL_W = 23;
  localparam int SOD_W    = 17;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;

  localparam int DAY_OFFSET    = 693594;
  localparam int DAY_SECONDS   = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int DAYS_Y1       = 365;
  localparam int DAYS_Y4       = 1461;
  localparam int DAYS_Y100     = 36524;
  localparam int DAYS_Y400     = 146097;
  localparam int YEAR_MAX      = 9999;
  localparam int MONTHS        = 12;

  localparam logic signed [SERIAL_W-1:0] SERIAL_INVALID = SERIAL_W'(-DAY_OFFSET);

  // reciprocal multipliers, quotient is product >> shift
  localparam int DIV25        = 25;
  localparam int DIV25_SHIFT  = 19;
  localparam int DIV25_MUL    = (2**DIV25_SHIFT + DIV25 - 1) / DIV25;
  localparam int SH400        = 23;
  localparam int RCP400       = 2**SH400 / DAYS_Y400;
  localparam int SH100        = 18;
  localparam int RCP100       = 2**SH100 / DAYS_Y100;
  localparam int SH4          = 16;
  localparam int RCP4         = 2**SH4 / DAYS_Y4;
  localparam int SH3600       = 17;
  localparam int RCP3600      = 2**SH3600 / SECS_PER_HOUR;
  localparam int SH60         = 12;
  localparam int RCP60        = 2**SH60 / SECS_PER_MIN;

  localparam int ENC_STAGES = 3;
  localparam int DEC_STAGES = 9;
  // stage 3 register plus the alignment delay
  localparam int ENC_PAD    = DEC_STAGES - ENC_STAGES + 1;

  typedef struct packed {
    logic signed [SERIAL_W-1:0] serial_day;
    logic [SOD_W-1:0]           second_of_day;
    logic                       ok;
  } enc_res_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic               ok;
  } dec_res_t;

  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] len;
    case (month) inside
      4'd2:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      [4'd1:4'd12]:           len = 5'd31;
      default:                len = 5'd0;
    endcase
    return len;
  endfunction

  // days of the year before the first of the month
  function automatic logic [8:0] cum_days(input logic leap, input logic [MONTH_W-1:0] month);
    logic [8:0] days;
    case (month)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    if (leap && month >= 4'd3 && month <= 4'd12) days = days + 9'd1;
    return days;
  endfunction

endpackage

// ===== design/cdconv_enc.sv =====
// calendar fields to serial day encoder, three stages plus alignment delay
module cdconv_enc
  import cdconv_pkg::*;
(
  input  logic               clk,
  input  logic               adv,
  input  logic [YEAR_W-1:0]  year_in,
  input  logic [MONTH_W-1:0] month_in,
  input  logic [DAY_W-1:0]   day_in,
  input  logic [HOUR_W-1:0]  hour_in,
  input  logic [MIN_W-1:0]   minute_in,
  input  logic [SEC_W-1:0]   second_in,
  output enc_res_t           res
);

  // stage 1
  logic [SOD_W-1:0]   total_s1;
  logic [YEAR_W-1:0]  p_s1;
  logic [SOD_W-1:0]   e1_total;
  logic [YEAR_W-1:0]  e1_year;
  logic [MONTH_W-1:0] e1_month;
  logic [DAY_W-1:0]   e1_day;
  logic [21:0]        e1_p365;
  logic [11:0]        e1_p4;
  logic [28:0]        e1_my;
  logic [28:0]        e1_mp4;
  logic [28:0]        e1_mp16;

  assign total_s1 = SOD_W'(hour_in) * SOD_W'(SECS_PER_HOUR)
                  + SOD_W'(minute_in) * SOD_W'(SECS_PER_MIN) + SOD_W'(second_in);
  assign p_s1 = year_in - 14'd1;

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_total <= total_s1;
      e1_year  <= year_in;
      e1_month <= month_in;
      e1_day   <= day_in;
      e1_p365  <= 22'(p_s1) * 22'(DAYS_Y1);
      e1_p4    <= p_s1[13:2];
      e1_my    <= 29'(year_in) * 29'(DIV25_MUL);
      e1_mp4   <= 29'(p_s1[13:2]) * 29'(DIV25_MUL);
      e1_mp16  <= 29'(p_s1[13:4]) * 29'(DIV25_MUL);
    end
  end

  // stage 2
  logic [9:0]         qy;
  logic               y25;
  logic               leap_s2;
  logic [21:0]        base_s2;
  logic               carry_s2;
  logic               range_s2;
  logic [21:0]        e2_base;
  logic               e2_leap;
  logic [MONTH_W-1:0] e2_month;
  logic [DAY_W-1:0]   e2_day;
  logic               e2_range;
  logic               e2_carry;
  logic [SOD_W-1:0]   e2_total;

  assign qy       = e1_my[DIV25_SHIFT +: 10];
  assign y25      = (e1_year == YEAR_W'(qy) * YEAR_W'(DIV25));
  assign leap_s2  = (e1_year[1:0] == 2'b00) && (!y25 || e1_year[3:0] == 4'b0000);
  assign base_s2  = e1_p365 + 22'(e1_p4) - 22'(e1_mp4[DIV25_SHIFT +: 10])
                  + 22'(e1_mp16[DIV25_SHIFT +: 10]);
  assign carry_s2 = e1_total >= SOD_W'(DAY_SECONDS);
  assign range_s2 = (e1_year != '0) && (e1_year <= YEAR_W'(YEAR_MAX)) && (e1_month != '0)
                 && (e1_month <= MONTH_W'(MONTHS)) && (e1_day != '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      e2_base  <= base_s2;
      e2_leap  <= leap_s2;
      e2_month <= e1_month;
      e2_day   <= e1_day;
      e2_range <= range_s2;
      e2_carry <= carry_s2;
      e2_total <= carry_s2 ? e1_total - SOD_W'(DAY_SECONDS) : e1_total;
    end
  end

  // stage 3
  logic       ok_s3;
  logic [8:0] doy_s3;
  logic [23:0] calc_s3;
  enc_res_t   res_s3;
  enc_res_t   dly [ENC_PAD];

  assign ok_s3   = e2_range && (e2_day <= month_len(e2_leap, e2_month));
  assign doy_s3  = cum_days(e2_leap, e2_month) + 9'(e2_day);
  assign calc_s3 = 24'(e2_base) + 24'(doy_s3) + 24'(e2_carry) - 24'(DAY_OFFSET);

  always_comb begin
    res_s3.serial_day    = ok_s3 ? SERIAL_W'(calc_s3) : SERIAL_INVALID;
    res_s3.second_of_day = e2_total;
    res_s3.ok            = ok_s3;
  end

  // delay to line up with the decoder
  always_ff @(posedge clk) begin
    if (adv) begin
      dly[0] <= res_s3;
      for (int i = 1; i < ENC_PAD; i++) dly[i] <= dly[i-1];
    end
  end

  assign res = dly[ENC_PAD-1];

endmodule

// ===== design/cdconv_dec.sv =====
// serial day and second of day decoder, nine register stages
module cdconv_dec
  import cdconv_pkg::*;
(
  input  logic                       clk,
  input  logic                       adv,
  input  logic signed [SERIAL_W-1:0] serial_day_in,
  input  logic [SOD_W-1:0]           second_of_day_in,
  output dec_res_t                   res
);

  // stage 1: day carry and absolute day
  logic               c_s1;
  logic [23:0]        t_s1;
  logic [22:0]        r1_d;
  logic               r1_neg;
  logic [SOD_W-1:0]   r1_secs;

  assign c_s1 = second_of_day_in >= SOD_W'(DAY_SECONDS);
  assign t_s1 = {serial_day_in[SERIAL_W-1], serial_day_in} + 24'(c_s1) + 24'(DAY_OFFSET);

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_d    <= 23'(t_s1 - 24'd1);
      r1_neg  <= t_s1[23] || (t_s1 == '0);
      r1_secs <= c_s1 ? second_of_day_in - SOD_W'(DAY_SECONDS) : second_of_day_in;
    end
  end

  // stage 2: reciprocal products for 400 years and hours
  logic [22:0]        r2_d;
  logic [28:0]        r2_p400;
  logic               r2_neg;
  logic [SOD_W-1:0]   r2_secs;
  logic [22:0]        r2_ph;

  always_ff @(posedge clk) begin
    if (adv) begin
      r2_d    <= r1_d;
      r2_p400 <= 29'(r1_d) * 29'(RCP400);
      r2_neg  <= r1_neg;
      r2_secs <= r1_secs;
      r2_ph   <= 23'(r1_secs) * 23'(RCP3600);
    end
  end

  // stage 3: 400 year quotient and hour
  logic [5:0]         q400e;
  logic [22:0]        rem400;
  logic               fix400;
  logic [5:0]         qhe;
  logic [SOD_W-1:0]   remh;
  logic               fixh;
  logic [17:0]        r3_d;
  logic [5:0]         r3_q400;
  logic               r3_neg;
  logic [HOUR_W-1:0]  r3_hour;
  logic [11:0]        r3_rem;

  assign q400e  = r2_p400[SH400 +: 6];
  assign rem400 = r2_d - 23'(q400e) * 23'(DAYS_Y400);
  assign fix400 = rem400 >= 23'(DAYS_Y400);
  assign qhe    = r2_ph[SH3600 +: 6];
  assign remh   = r2_secs - SOD_W'(qhe) * SOD_W'(SECS_PER_HOUR);
  assign fixh   = remh >= SOD_W'(SECS_PER_HOUR);

  always_ff @(posedge clk) begin
    if (adv) begin
      r3_d    <= 18'(fix400 ? rem400 - 23'(DAYS_Y400) : rem400);
      r3_q400 <= q400e + 6'(fix400);
      r3_neg  <= r2_neg;
      r3_hour <= HOUR_W'(qhe + 6'(fixh));
      r3_rem  <= 12'(fixh ? remh - SOD_W'(SECS_PER_HOUR) : remh);
    end
  end

  // stage 4: reciprocal products for centuries and minutes
  logic [17:0]        r4_d;
  logic [20:0]        r4_p100;
  logic [5:0]         r4_q400;
  logic               r4_neg;
  logic [HOUR_W-1:0]  r4_hour;
  logic [11:0]        r4_rem;
  logic [18:0]        r4_p60;

  always_ff @(posedge clk) begin
    if (adv) begin
      r4_d    <= r3_d;
      r4_p100 <= 21'(r3_d) * 21'(RCP100);
      r4_q400 <= r3_q400;
      r4_neg  <= r3_neg;
      r4_hour <= r3_hour;
      r4_rem  <= r3_rem;
      r4_p60  <= 19'(r3_rem) * 19'(RCP60);
    end
  end

  // stage 5: century quotient with the fourth century clamp, minute and second
  logic [2:0]         q100e;
  logic [17:0]        rem100;
  logic               fix100;
  logic [2:0]         q100c;
  logic [17:0]        rem100c;
  logic               clamp100;
  logic [6:0]         q60e;
  logic [11:0]        remm;
  logic               fixm;
  logic [15:0]        r5_d;
  logic [5:0]         r5_q400;
  logic [1:0]         r5_q100;
  logic               r5_neg;
  logic [HOUR_W-1:0]  r5_hour;
  logic [MIN_W-1:0]   r5_minute;
  logic [SEC_W-1:0]   r5_second;

  assign q100e    = r4_p100[SH100 +: 3];
  assign rem100   = r4_d - 18'(q100e) * 18'(DAYS_Y100);
  assign fix100   = rem100 >= 18'(DAYS_Y100);
  assign q100c    = q100e + 3'(fix100);
  assign rem100c  = fix100 ? rem100 - 18'(DAYS_Y100) : rem100;
  assign clamp100 = (q100c == 3'd4);
  assign q60e     = r4_p60[SH60 +: 7];
  assign remm     = r4_rem - 12'(q60e) * 12'(SECS_PER_MIN);
  assign fixm     = remm >= 12'(SECS_PER_MIN);

  always_ff @(posedge clk) begin
    if (adv) begin
      r5_d      <= 16'(clamp100 ? rem100c + 18'(DAYS_Y100) : rem100c);
      r5_q400   <= r4_q400;
      r5_q100   <= clamp100 ? 2'd3 : q100c[1:0];
      r5_neg    <= r4_neg;
      r5_hour   <= r4_hour;
      r5_minute <= MIN_W'(q60e + 7'(fixm));
      r5_second <= SEC_W'(fixm ? remm - 12'(SECS_PER_MIN) : remm);
    end
  end

  // stage 6: reciprocal product for four year cycles
  logic [15:0]        r6_d;
  logic [21:0]        r6_p4;
  logic [5:0]         r6_q400;
  logic [1:0]         r6_q100;
  logic               r6_neg;
  logic [HOUR_W-1:0]  r6_hour;
  logic [MIN_W-1:0]   r6_minute;
  logic [SEC_W-1:0]   r6_second;

  always_ff @(posedge clk) begin
    if (adv) begin
      r6_d      <= r5_d;
      r6_p4     <= 22'(r5_d) * 22'(RCP4);
      r6_q400   <= r5_q400;
      r6_q100   <= r5_q100;
      r6_neg    <= r5_neg;
      r6_hour   <= r5_hour;
      r6_minute <= r5_minute;
      r6_second <= r5_second;
    end
  end

  // stage 7: four year quotient
  logic [5:0]         q4e;
  logic [15:0]        rem4;
  logic               fix4;
  logic [10:0]        r7_r;
  logic [4:0]         r7_q4;
  logic [5:0]         r7_q400;
  logic [1:0]         r7_q100;
  logic               r7_neg;
  logic [HOUR_W-1:0]  r7_hour;
  logic [MIN_W-1:0]   r7_minute;
  logic [SEC_W-1:0]   r7_second;

  assign q4e  = r6_p4[SH4 +: 6];
  assign rem4 = r6_d - 16'(q4e) * 16'(DAYS_Y4);
  assign fix4 = rem4 >= 16'(DAYS_Y4);

  always_ff @(posedge clk) begin
    if (adv) begin
      r7_r      <= 11'(fix4 ? rem4 - 16'(DAYS_Y4) : rem4);
      r7_q4     <= 5'(q4e + 6'(fix4));
      r7_q400   <= r6_q400;
      r7_q100   <= r6_q100;
      r7_neg    <= r6_neg;
      r7_hour   <= r6_hour;
      r7_minute <= r6_minute;
      r7_second <= r6_second;
    end
  end

  // stage 8: single years, year number and leap flag
  logic [1:0]         q1;
  logic [8:0]         r8_doy;
  logic [YEAR_W-1:0]  r8_year;
  logic               r8_leap;
  logic               r8_neg;
  logic [HOUR_W-1:0]  r8_hour;
  logic [MIN_W-1:0]   r8_minute;
  logic [SEC_W-1:0]   r8_second;

  always_comb begin
    if (r7_r >= 11'(3 * DAYS_Y1))      q1 = 2'd3;
    else if (r7_r >= 11'(2 * DAYS_Y1)) q1 = 2'd2;
    else if (r7_r >= 11'(DAYS_Y1))     q1 = 2'd1;
    else                               q1 = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r8_doy    <= 9'(r7_r - 11'(q1) * 11'(DAYS_Y1));
      r8_year   <= YEAR_W'(1) + YEAR_W'(r7_q400) * YEAR_W'(400)
                 + YEAR_W'(r7_q100) * YEAR_W'(100) + YEAR_W'({r7_q4, 2'b00}) + YEAR_W'(q1);
      r8_leap   <= (q1 == 2'd3) && (r7_q4 != 5'd24 || r7_q100 == 2'd3);
      r8_neg    <= r7_neg;
      r8_hour   <= r7_hour;
      r8_minute <= r7_minute;
      r8_second <= r7_second;
    end
  end

  // stage 9: month compare ladder
  logic [MONTH_W-1:0] month_s9;
  logic [8:0]         r9_doy;
  logic [MONTH_W-1:0] r9_month;
  logic [YEAR_W-1:0]  r9_year;
  logic               r9_leap;
  logic               r9_neg;
  logic [HOUR_W-1:0]  r9_hour;
  logic [MIN_W-1:0]   r9_minute;
  logic [SEC_W-1:0]   r9_second;

  always_comb begin
    month_s9 = MONTH_W'(1);
    for (int k = 2; k <= MONTHS; k++) begin
      if (r8_doy >= cum_days(r8_leap, MONTH_W'(k))) month_s9 = month_s9 + MONTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r9_doy    <= r8_doy;
      r9_month  <= month_s9;
      r9_year   <= r8_year;
      r9_leap   <= r8_leap;
      r9_neg    <= r8_neg;
      r9_hour   <= r8_hour;
      r9_minute <= r8_minute;
      r9_second <= r8_second;
    end
  end

  // day of month and the non-positive day case
  always_comb begin
    res.hour   = r9_hour;
    res.minute = r9_minute;
    res.second = r9_second;
    if (r9_neg) begin
      res.year  = '0;
      res.month = MONTH_W'(1);
      res.day   = DAY_W'(1);
      res.ok    = 1'b0;
    end else begin
      res.year  = r9_year;
      res.month = r9_month;
      res.day   = DAY_W'(r9_doy - cum_days(r9_leap, r9_month) + 9'd1);
      res.ok    = 1'b1;
    end
  end

endmodule

// ===== design/civil_date_serial_day_converter_core.sv =====
// top level of the civil date and serial day converter
// Takes one item per clock unless stalled and returns its result through nine pipeline
// stages and the output register. The depth is set by the decode path, which divides
// the day count by the 400, 100 and 4 year cycle lengths with a reciprocal multiply
// stage followed by a remainder and correction stage each, then walks the months in a
// compare ladder. The encode path is shorter and is delayed to match. The pipeline moves
// as a whole: in_ready is high whenever the output register is empty or being taken.
module civil_date_serial_day_converter_core
  import cdconv_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       cmd,
  input  logic [YEAR_W-1:0]          year_in,
  input  logic [MONTH_W-1:0]         month_in,
  input  logic [DAY_W-1:0]           day_in,
  input  logic [HOUR_W-1:0]          hour_in,
  input  logic [MIN_W-1:0]           minute_in,
  input  logic [SEC_W-1:0]           second_in,
  input  logic signed [SERIAL_W-1:0] serial_day_in,
  input  logic [SOD_W-1:0]           second_of_day_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SERIAL_W-1:0] serial_day_out,
  output logic [SOD_W-1:0]           second_of_day_out,
  output logic [YEAR_W-1:0]          year_out,
  output logic [MONTH_W-1:0]         month_out,
  output logic [DAY_W-1:0]           day_out,
  output logic [HOUR_W-1:0]          hour_out,
  output logic [MIN_W-1:0]           minute_out,
  output logic [SEC_W-1:0]           second_out,
  output logic                       valid_res
);

  logic                  adv;
  logic [DEC_STAGES-1:0] vld;
  logic [DEC_STAGES-1:0] cmd_p;
  enc_res_t              enc_res;
  dec_res_t              dec_res;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  cdconv_enc u_enc (
    .clk       (clk),
    .adv       (adv),
    .year_in   (year_in),
    .month_in  (month_in),
    .day_in    (day_in),
    .hour_in   (hour_in),
    .minute_in (minute_in),
    .second_in (second_in),
    .res       (enc_res)
  );

  cdconv_dec u_dec (
    .clk              (clk),
    .adv              (adv),
    .serial_day_in    (serial_day_in),
    .second_of_day_in (second_of_day_in),
    .res              (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[DEC_STAGES-2:0], in_valid};
      out_valid <= vld[DEC_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) cmd_p <= {cmd_p[DEC_STAGES-2:0], cmd};
  end

  // output register, fields of the other mode read zero
  always_ff @(posedge clk) begin
    if (adv && vld[DEC_STAGES-1]) begin
      if (cmd_p[DEC_STAGES-1] == CMD_DECODE) begin
        serial_day_out    <= '0;
        second_of_day_out <= '0;
        year_out          <= dec_res.year;
        month_out         <= dec_res.month;
        day_out           <= dec_res.day;
        hour_out          <= dec_res.hour;
        minute_out        <= dec_res.minute;
        second_out        <= dec_res.second;
        valid_res         <= dec_res.ok;
      end else begin
        serial_day_out    <= enc_res.serial_day;
        second_of_day_out <= enc_res.second_of_day;
        year_out          <= '0;
        month_out         <= '0;
        day_out           <= '0;
        hour_out          <= '0;
        minute_out        <= '0;
        second_out        <= '0;
        valid_res         <= enc_res.ok;
      end
    end
  end

  a_item_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted item not marked in first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld) && $stable(cmd_p))
    else $error("pipeline moved during a stall");

  a_decode_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && month_out != '0 |-> serial_day_out == '0 && second_of_day_out == '0
      && hour_out <= HOUR_W'(23))
    else $error("decode result carries encode fields");

  a_encode_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && month_out == '0 |-> year_out == '0 && day_out == '0 && hour_out == '0
      && minute_out == '0 && second_out == '0)
    else $error("encode result carries decode fields");

  a_encode_sentinel: assert property (@(posedge clk) disable iff (rst)
    out_valid && month_out == '0 && !valid_res |-> serial_day_out == SERIAL_INVALID)
    else $error("invalid date without sentinel serial");

endmodule
